@@ hw/rtl/hlv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlv_pkg: shared types and constants of the Hough line vote accumulator
// Holds the field widths, the item kind codes, the queued command type and
// the Q1.16 cosine and sine tables, which are built during elaboration.
// ----------------------------------------------------------------------------
package hlv_pkg;

  // Number of angle bins; the trig tables are sized by it.
  localparam int THETA_BINS = 180;

  localparam int KIND_W   = 2;
  localparam int COORD_W  = 10;
  localparam int PIXEL_W  = 8;
  localparam int ANGLE_W  = 8;
  localparam int RHO_W    = 12;
  localparam int COUNT_W  = 16;
  localparam int OFFSET_W = 11;
  localparam int TRIG_W   = 18;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 11'd1448;
  localparam logic [PIXEL_W-1:0]  PIXEL_ON     = 8'd255;

  localparam logic [KIND_W-1:0] KIND_VOTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_VOTE,
    OP_READ,
    OP_CLEAR
  } op_t;

  // One command as it waits in the queue between front and back.
  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ANGLE_W-1:0] angle;
    logic [RHO_W-1:0]   rho;
    logic               hit;
  } cmd_t;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [THETA_BINS];

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Divides a series term by the factorial step of term k.
  function automatic logic [63:0] div_term(input logic [63:0] v, input int k,
                                           input bit want_sin);
    logic [63:0] q;
    q = v;
    case (k)
      1:       q = want_sin ? v / 64'd6   : v / 64'd2;
      2:       q = want_sin ? v / 64'd20  : v / 64'd12;
      3:       q = want_sin ? v / 64'd42  : v / 64'd30;
      4:       q = want_sin ? v / 64'd72  : v / 64'd56;
      5:       q = want_sin ? v / 64'd110 : v / 64'd90;
      6:       q = want_sin ? v / 64'd156 : v / 64'd132;
      7:       q = want_sin ? v / 64'd210 : v / 64'd182;
      8:       q = want_sin ? v / 64'd272 : v / 64'd240;
      9:       q = want_sin ? v / 64'd342 : v / 64'd306;
      10:      q = want_sin ? v / 64'd420 : v / 64'd380;
      default: q = v;
    endcase
    return q;
  endfunction

  // Taylor series of sin or cos over the first quadrant, angle in Q30.
  function automatic logic signed [63:0] series_q30(input logic [63:0] a,
                                                    input bit want_sin);
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    a2   = (a * a) >> 30;
    term = want_sin ? a : ONE_Q30;
    sum  = signed'(term);
    for (int k = 1; k <= 10; k++) begin
      term = div_term((term * a2) >> 30, k, want_sin);
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  // Rounds Q30 to Q16, to nearest, clamping negative values to zero.
  function automatic logic signed [TRIG_W-1:0] q30_to_q16(input logic signed [63:0] v);
    logic [63:0] u;
    logic [63:0] r;
    u = (v < 0) ? 64'd0 : unsigned'(v);
    r = (u + 64'd8192) >> 14;
    return signed'(r[TRIG_W-1:0]);
  endfunction

  function automatic trig_tab_t build_trig(input bit want_sin);
    trig_tab_t                 tab;
    logic [63:0]               mm;
    logic [63:0]               a;
    logic signed [TRIG_W-1:0]  c;
    bit                        folded;
    for (int m = 0; m < THETA_BINS; m++) begin
      folded = (2 * m > THETA_BINS);
      mm     = folded ? 64'(THETA_BINS - m) : 64'(m);
      a      = (PI_Q30 * mm) / THETA_BINS;
      c      = q30_to_q16(series_q30(a, want_sin));
      tab[m] = (!want_sin && folded) ? -c : c;
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig(1'b1);

endpackage
`default_nettype wire

@@ hw/rtl/hough_line_vote_accumulator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator: Hough line voting accumulator
// Counts line votes per (angle, rho) cell, serves cell reads and clears.
// ----------------------------------------------------------------------------
// Usage. A command transaction is taken at a rising edge where start is high
// and busy is low. in_kind selects a vote (pixel at in_x_coord, in_y_coord,
// voting only when in_pixel_value is 255), a read of one cell (in_angle_index,
// in_rho_index) or a clear of all cells. Votes with other pixel values and
// the unused kind are taken and dropped.
// Commands wait in a four-entry queue; busy rises when it is full.
// A vote occupies the back end for one read-modify-write of the vote store
// per angle; its last writes are still in the pipeline when it leaves.
// A read first waits for in-flight vote writes to finish, then returns its
// count on out_vote_count with out_valid high for exactly one cycle, once it
// has passed the read and read-wait states. Out-of-range cells read as zero.
// A clear sweeps the store one cell per cycle over all THETA_BINS * RHO_BINS
// cells (737280 at the defaults); commands queue up behind it meanwhile.
// Reset (rst_n low, synchronous) starts the same sweep and holds busy high
// until it is done. The receiver cannot stall: results are never held.
// rho_offset is written over the cfg_ channel (always ready) while idle.
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator import hlv_pkg::*; #(
  parameter int RHO_BINS   = 4096,
  parameter int COORD_BITS = 10,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Command channel.
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [COORD_W-1:0]  in_x_coord,
  input  wire logic [COORD_W-1:0]  in_y_coord,
  input  wire logic [PIXEL_W-1:0]  in_pixel_value,
  input  wire logic [ANGLE_W-1:0]  in_angle_index,
  input  wire logic [RHO_W-1:0]    in_rho_index,
  // Result channel.
  output logic                     out_valid,
  output logic      [COUNT_W-1:0]  out_vote_count,
  // Configuration channel.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [OFFSET_W-1:0] cfg_rho_offset
);

  localparam int QUEUE_DEPTH = 4;

  logic [OFFSET_W-1:0] rho_offset_r;
  logic                q_full, q_empty, q_push, q_pop;
  cmd_t                push_cmd, pop_cmd;
  logic                clr_busy;

  // The offset register takes every write; the user must write it only while
  // the block is idle, so no in-flight vote sees a change. It is not checked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_offset_r <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rho_offset_r <= cfg_rho_offset;
    end
  end

  // Front end: accepts and classifies command transactions.
  hlv_front #(
    .RHO_BINS   (RHO_BINS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .kind        (in_kind),
    .x_coord     (in_x_coord),
    .y_coord     (in_y_coord),
    .pixel_value (in_pixel_value),
    .angle_index (in_angle_index),
    .rho_index   (in_rho_index),
    .q_full      (q_full),
    .clr_busy    (clr_busy),
    .push        (q_push),
    .cmd         (push_cmd)
  );

  // The queue decouples the front from the long-running back end.
  hlv_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  // Back end: vote pipeline, reads and clearing sweeps over the store.
  hlv_back #(
    .RHO_BINS   (RHO_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rho_offset     (rho_offset_r),
    .q_empty        (q_empty),
    .q_data         (pop_cmd),
    .q_pop          (q_pop),
    .clr_busy       (clr_busy),
    .out_valid      (out_valid),
    .out_vote_count (out_vote_count)
  );

endmodule
`default_nettype wire

@@ hw/rtl/hlv_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlv_ram: generic single-write, single-read memory
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module hlv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hlv_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlv_queue: short command queue between front and back
// A small first-in first-out buffer in flip-flops.
// ----------------------------------------------------------------------------
module hlv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hlv_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlv_front: accepts input transactions and classifies them
// Drops items that do nothing, masks coordinates, range-checks reads and
// hands the resulting command to the queue.
// ----------------------------------------------------------------------------
module hlv_front import hlv_pkg::*; #(
  parameter int RHO_BINS   = 4096,
  parameter int COORD_BITS = 10
) (
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [KIND_W-1:0]  kind,
  input  wire logic [COORD_W-1:0] x_coord,
  input  wire logic [COORD_W-1:0] y_coord,
  input  wire logic [PIXEL_W-1:0] pixel_value,
  input  wire logic [ANGLE_W-1:0] angle_index,
  input  wire logic [RHO_W-1:0]   rho_index,
  input  wire logic               q_full,
  input  wire logic               clr_busy,
  output logic                    push,
  output cmd_t                    cmd
);

  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  logic accept;

  assign busy   = q_full || clr_busy;
  assign accept = start && !busy;

  always_comb begin
    cmd.op    = OP_VOTE;
    cmd.x     = x_coord & COORD_MASK;
    cmd.y     = y_coord & COORD_MASK;
    cmd.angle = angle_index;
    cmd.rho   = rho_index;
    cmd.hit   = (int'(angle_index) < THETA_BINS) && (int'(rho_index) < RHO_BINS);
    push      = 1'b0;
    case (kind)
      KIND_VOTE: begin
        cmd.op = OP_VOTE;
        push   = accept && (pixel_value == PIXEL_ON);
      end
      KIND_READ: begin
        cmd.op = OP_READ;
        push   = accept;
      end
      KIND_CLEAR: begin
        cmd.op = OP_CLEAR;
        push   = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/hlv_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlv_back: executes queued commands against the vote store
// A sequencer walks the angles of a vote through a read-modify-write
// pipeline, serves reads and sweeps the store for a clear.
// ----------------------------------------------------------------------------
module hlv_back import hlv_pkg::*; #(
  parameter int RHO_BINS   = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [OFFSET_W-1:0] rho_offset,
  input  wire logic                q_empty,
  input  wire cmd_t                q_data,
  output logic                     q_pop,
  output logic                     clr_busy,
  output logic                     out_valid,
  output logic      [COUNT_W-1:0]  out_vote_count
);

  localparam int DEPTH = THETA_BINS * RHO_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(RHO_BINS);
  localparam int PW    = COORD_W + TRIG_W + 1;
  localparam int TW    = PW + 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOTE,
    ST_READ,
    ST_RWAIT,
    ST_CLEAR
  } state_t;

  state_t               state_r, state_nxt;
  logic [ANGLE_W-1:0]   ang_r, ang_nxt;
  logic [AW-1:0]        row_r, row_nxt;
  logic [COORD_W-1:0]   vx_r, vx_nxt;
  logic [COORD_W-1:0]   vy_r, vy_nxt;
  logic [AW-1:0]        rd_addr_r, rd_addr_nxt;
  logic                 rd_hit_r, rd_hit_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 init_r, init_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  // Vote pipeline: table, multiply, bin, write back.
  logic                     t_v_r;
  logic signed [TRIG_W-1:0] t_cos_r, t_sin_r;
  logic [COORD_W-1:0]       t_x_r, t_y_r;
  logic [AW-1:0]            t_row_r;
  logic                     m_v_r;
  logic signed [PW-1:0]     m_px_r, m_py_r;
  logic [AW-1:0]            m_row_r;
  logic                     b_v_r;
  logic [NW-1:0]            b_n_r;
  logic [AW-1:0]            b_row_r;
  logic                     w_v_r;
  logic [AW-1:0]            w_addr_r;

  logic signed [TW-1:0]  rho_sum;
  logic [TW-2:16]        n_raw;
  logic                  n_ok;
  logic                  drained;
  logic                  ram_wr_en, ram_rd_en;
  logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;
  logic [31:0]           count_wide;

  assign drained    = !(t_v_r || m_v_r || b_v_r || w_v_r);
  assign clr_busy   = init_r;
  assign out_valid  = out_valid_r;
  assign out_vote_count = out_count_r;
  assign count_wide = 32'(ram_rd_data);

  always_comb begin
    state_nxt     = state_r;
    ang_nxt       = ang_r;
    row_nxt       = row_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    rd_addr_nxt   = rd_addr_r;
    rd_hit_nxt    = rd_hit_r;
    clr_addr_nxt  = clr_addr_r;
    init_nxt      = init_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_data.op)
            OP_VOTE: begin
              q_pop     = 1'b1;
              vx_nxt    = q_data.x;
              vy_nxt    = q_data.y;
              ang_nxt   = '0;
              row_nxt   = '0;
              state_nxt = ST_VOTE;
            end
            OP_READ: begin
              if (drained) begin
                q_pop       = 1'b1;
                rd_hit_nxt  = q_data.hit;
                rd_addr_nxt = AW'(q_data.angle) * AW'(RHO_BINS) + AW'(q_data.rho);
                state_nxt   = ST_READ;
              end
            end
            OP_CLEAR: begin
              if (drained) begin
                q_pop        = 1'b1;
                clr_addr_nxt = '0;
                state_nxt    = ST_CLEAR;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_VOTE: begin
        if (ang_r == ANGLE_W'(THETA_BINS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          ang_nxt = ang_r + 1'b1;
          row_nxt = row_r + AW'(RHO_BINS);
        end
      end
      ST_READ: begin
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        out_valid_nxt = 1'b1;
        out_count_nxt = rd_hit_r ? count_wide[COUNT_W-1:0] : '0;
        state_nxt     = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ang_r       <= ang_nxt;
    row_r       <= row_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_hit_r    <= rd_hit_nxt;
    out_count_r <= out_count_nxt;
  end

  // Bin stage arithmetic: rho plus offset plus one half, in Q.16.
  assign rho_sum = TW'(m_px_r) + TW'(m_py_r)
                 + signed'(TW'({rho_offset, 16'h8000}));
  assign n_raw   = rho_sum[TW-2:16];
  assign n_ok    = !rho_sum[TW-1] && (int'(n_raw) < RHO_BINS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      m_v_r <= 1'b0;
      b_v_r <= 1'b0;
      w_v_r <= 1'b0;
    end else begin
      t_v_r <= (state_r == ST_VOTE);
      m_v_r <= t_v_r;
      b_v_r <= m_v_r && n_ok;
      w_v_r <= b_v_r;
    end
    t_cos_r  <= COS_TAB[ang_r];
    t_sin_r  <= SIN_TAB[ang_r];
    t_x_r    <= vx_r;
    t_y_r    <= vy_r;
    t_row_r  <= row_r;
    m_px_r   <= PW'(signed'({1'b0, t_x_r}) * t_cos_r);
    m_py_r   <= PW'(signed'({1'b0, t_y_r}) * t_sin_r);
    m_row_r  <= t_row_r;
    b_n_r    <= NW'(n_raw);
    b_row_r  <= m_row_r;
    w_addr_r <= ram_rd_addr;
  end

  assign ram_rd_en   = b_v_r || ((state_r == ST_READ) && rd_hit_r);
  assign ram_rd_addr = b_v_r ? (b_row_r + AW'(b_n_r)) : rd_addr_r;

  assign ram_wr_en   = w_v_r || (state_r == ST_CLEAR);
  assign ram_wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : w_addr_r;
  assign ram_wr_data = (state_r == ST_CLEAR) ? '0
                     : ((ram_rd_data == COUNT_MAX) ? ram_rd_data : ram_rd_data + 1'b1);

  hlv_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_en     (ram_rd_en),
    .rd_addr   (ram_rd_addr),
    .rd_data_r (ram_rd_data)
  );

endmodule
`default_nettype wire

@@ hw/rtl/hlv_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlv_checker: port-level checks of the Hough line vote accumulator
// Watches reset behavior and the spacing of results on the top level ports.
// ----------------------------------------------------------------------------
module hlv_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid
);

  // Reset starts the clearing sweep, so the block must refuse commands.
  assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // No result may come out of reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Every read passes the read and read-wait states, so results never come back to back.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

endmodule

bind hough_line_vote_accumulator hlv_checker u_hlv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

@@ dv/hlv_count_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hlv_count_checker: vote count predictor and result checker
// Watches the command, result and rho_offset channels of the Hough line vote
// accumulator, keeps its own copy of the vote store and trig tables, and
// compares every returned count with the oldest count owed by a read.
// ----------------------------------------------------------------------------
module hlv_count_checker import hlv_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [COORD_W-1:0]  in_x_coord,
  input  wire logic [COORD_W-1:0]  in_y_coord,
  input  wire logic [PIXEL_W-1:0]  in_pixel_value,
  input  wire logic [ANGLE_W-1:0]  in_angle_index,
  input  wire logic [RHO_W-1:0]    in_rho_index,
  input  wire logic                out_valid,
  input  wire logic [COUNT_W-1:0]  out_vote_count,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [OFFSET_W-1:0] cfg_rho_offset,
  output int                       fail_count,
  output int                       owed_total
);

  localparam int RHO_CELLS = 4096;
  localparam int COUNT_MAX = 65535;

  int                  cos_q16 [THETA_BINS];
  int                  sin_q16 [THETA_BINS];
  int                  cell_count [int];
  logic [COUNT_W-1:0]  owed_counts [$];
  logic [OFFSET_W-1:0] rho_offset_now;

  // Taylor series of sin or cos over the first quadrant, angle in Q30.
  function automatic longint taylor_q30(input longint unsigned a, input bit want_sin);
    longint unsigned a2;
    longint unsigned term;
    longint unsigned d;
    longint          sum;
    a2   = (a * a) >> 30;
    term = want_sin ? a : ONE_Q30;
    sum  = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      d    = want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
      term = ((term * a2) >> 30) / d;
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // Q30 to Q16, rounded to nearest, negative values clamped to zero.
  function automatic int round_q16(input longint v);
    if (v < 0) begin
      v = 0;
    end
    return int'((v + 8192) >> 14);
  endfunction

  // One vote per angle for an edge pixel; bins outside the store are skipped.
  task automatic tally_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    longint base;
    longint t;
    longint n;
    int     idx;
    base = (longint'(rho_offset_now) << 16) + 32768;
    for (int m = 0; m < THETA_BINS; m++) begin
      t = longint'(x) * cos_q16[m] + longint'(y) * sin_q16[m] + base;
      if (t >= 0) begin
        n = t >>> 16;
        if (n < RHO_CELLS) begin
          idx = m * RHO_CELLS + int'(n);
          if (!cell_count.exists(idx)) begin
            cell_count[idx] = 0;
          end
          if (cell_count[idx] < COUNT_MAX) begin
            cell_count[idx] = cell_count[idx] + 1;
          end
        end
      end
    end
  endtask

  initial begin
    bit              folded;
    longint unsigned mm;
    longint unsigned a;
    int              c;
    // Angles past ninety degrees reuse the mirrored first-quadrant angle.
    for (int m = 0; m < THETA_BINS; m++) begin
      folded     = (2 * m > THETA_BINS);
      mm         = folded ? THETA_BINS - m : m;
      a          = (PI_Q30 * mm) / THETA_BINS;
      c          = round_q16(taylor_q30(a, 1'b0));
      sin_q16[m] = round_q16(taylor_q30(a, 1'b1));
      cos_q16[m] = folded ? -c : c;
    end
  end

  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    int                 idx;
    if (!rst_n) begin
      cell_count.delete();
      owed_counts.delete();
      rho_offset_now = OFFSET_RESET;
      fail_count     = 0;
    end else begin
      if (out_valid) begin
        if (owed_counts.size() == 0) begin
          $error("vote_count with no read waiting: expected none, actual %0d",
                 out_vote_count);
          fail_count = fail_count + 1;
        end else begin
          want = owed_counts.pop_front();
          if (out_vote_count !== want) begin
            $error("vote_count mismatch: expected %0d, actual %0d", want, out_vote_count);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        rho_offset_now = cfg_rho_offset;
      end
      if (start && !busy) begin
        case (in_kind)
          KIND_VOTE: begin
            if (in_pixel_value == PIXEL_ON) begin
              tally_pixel(in_x_coord, in_y_coord);
            end
          end
          KIND_READ: begin
            want = '0;
            if (in_angle_index < THETA_BINS) begin
              idx = int'(in_angle_index) * RHO_CELLS + int'(in_rho_index);
              if (cell_count.exists(idx)) begin
                want = cell_count[idx][COUNT_W-1:0];
              end
            end
            owed_counts = {owed_counts, want};
          end
          KIND_CLEAR: begin
            cell_count.delete();
          end
          default: begin
          end
        endcase
      end
    end
    owed_total = owed_counts.size();
  end

endmodule

@@ dv/hough_line_vote_accumulator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator_tb: top of the vote accumulator regression
// Drives directed and random vote, read, clear and unused-kind commands,
// rewrites rho_offset between phases, and takes the verdict from the count
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator_tb;
  import hlv_pkg::*;

  // The spare kind code is taken and dropped by the block.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // The reset sweep and a clear each write all 737280 cells one by one, so
  // the watchdog allows well over one sweep before it calls the run hung.
  localparam int QUIET_LIMIT  = 3000000;
  // Quiet cycles after the last count before the offset may change.
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 1000;
  localparam int PHASE_ITEMS   = 230;
  localparam int POOL_SIZE     = 8;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [COORD_W-1:0]  in_x_coord;
  logic [COORD_W-1:0]  in_y_coord;
  logic [PIXEL_W-1:0]  in_pixel_value;
  logic [ANGLE_W-1:0]  in_angle_index;
  logic [RHO_W-1:0]    in_rho_index;
  logic                out_valid;
  logic [COUNT_W-1:0]  out_vote_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_rho_offset;

  int                  fail_count;
  int                  owed_total;
  int                  quiet_cycles;

  // The offset the block should be using, kept here only to aim reads at
  // cells that have collected votes.
  logic [OFFSET_W-1:0] cur_offset;
  logic [COORD_W-1:0]  pool_x [POOL_SIZE];
  logic [COORD_W-1:0]  pool_y [POOL_SIZE];
  bit                  idle_on;

  hough_line_vote_accumulator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_pixel_value (in_pixel_value),
    .in_angle_index (in_angle_index),
    .in_rho_index   (in_rho_index),
    .out_valid      (out_valid),
    .out_vote_count (out_vote_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_rho_offset (cfg_rho_offset)
  );

  hlv_count_checker count_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_pixel_value (in_pixel_value),
    .in_angle_index (in_angle_index),
    .in_rho_index   (in_rho_index),
    .out_valid      (out_valid),
    .out_vote_count (out_vote_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_rho_offset (cfg_rho_offset),
    .fail_count     (fail_count),
    .owed_total     (owed_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The watchdog counts cycles in which no transaction moves on any channel.
  // Long stretches are expected during the reset sweep and a clear.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one command from a falling edge and holds it until the block
  // takes it. Start stays high on return, so back-to-back commands need no
  // extra edge; the caller lowers it when it wants a gap.
  task automatic issue_command(input logic [KIND_W-1:0] kind,
                               input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic [PIXEL_W-1:0] pix,
                               input logic [ANGLE_W-1:0] ang,
                               input logic [RHO_W-1:0] rho);
    start          = 1'b1;
    in_kind        = kind;
    in_x_coord     = x;
    in_y_coord     = y;
    in_pixel_value = pix;
    in_angle_index = ang;
    in_rho_index   = rho;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Unused fields of a command carry random bits so every bit toggles.
  task automatic send_vote(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [PIXEL_W-1:0] pix);
    issue_command(KIND_VOTE, x, y, pix, ANGLE_W'($urandom), RHO_W'($urandom));
  endtask

  task automatic send_read(input logic [ANGLE_W-1:0] ang, input logic [RHO_W-1:0] rho);
    issue_command(KIND_READ, COORD_W'($urandom), COORD_W'($urandom),
                  PIXEL_W'($urandom), ang, rho);
  endtask

  // The rho bin a pixel votes into at one angle, worked out in real numbers.
  // It may be off by one from the block's fixed-point result, which is fine
  // for aiming reads; the checker holds the exact prediction.
  function automatic int aim_rho(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input int ang);
    real th;
    real r;
    th = 3.141592653589793 * ang / 180.0;
    r  = x * $cos(th) + y * $sin(th) + cur_offset + 0.5;
    return $rtoi($floor(r));
  endfunction

  // Stops sending and waits until every read has been answered. Reads wait
  // for earlier vote writes to land, so when the last count is back the
  // block is idle.
  task automatic wait_for_counts();
    start = 1'b0;
    while (owed_total != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    cfg_valid      = 1'b1;
    cfg_rho_offset = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  = 1'b0;
    cur_offset = value;
  endtask

  // One phase of random traffic. Most votes come from a small pool of edge
  // pixels so that cells build up counts, and most reads are aimed at cells
  // those pixels hit. The phase ends with a read so that draining it proves
  // all of its votes have landed.
  task automatic run_phase(input int n_items, input bit with_gaps);
    int pick;
    int p;
    int ang;
    int rho;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_x[i] = COORD_W'($urandom);
      pool_y[i] = COORD_W'($urandom);
    end
    idle_on = with_gaps;
    for (int i = 0; i < n_items; i++) begin
      if (with_gaps && i % 50 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      p    = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 35) begin
        send_vote(pool_x[p], pool_y[p], PIXEL_ON);
      end else if (pick < 45) begin
        send_vote(COORD_W'($urandom), COORD_W'($urandom), PIXEL_ON);
      end else if (pick < 55) begin
        send_vote(COORD_W'($urandom), COORD_W'($urandom), PIXEL_W'($urandom));
      end else if (pick < 95) begin
        if (pick < 80) begin
          ang = $urandom_range(0, THETA_BINS - 1);
          rho = aim_rho(pool_x[p], pool_y[p], ang) + $urandom_range(0, 2) - 1;
          if (rho < 0 || rho > 4095) begin
            rho = $urandom_range(0, 4095);
          end
        end else begin
          ang = $urandom_range(0, 255);
          rho = $urandom_range(0, 4095);
        end
        send_read(ANGLE_W'(ang), RHO_W'(rho));
      end else begin
        issue_command(KIND_SPARE, COORD_W'($urandom), COORD_W'($urandom),
                      PIXEL_W'($urandom), ANGLE_W'($urandom), RHO_W'($urandom));
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
    end
    ang = $urandom_range(0, THETA_BINS - 1);
    send_read(ANGLE_W'(ang), RHO_W'(aim_rho(pool_x[0], pool_y[0], ang)));
    wait_for_counts();
  endtask

  initial begin
    logic [OFFSET_W-1:0] phase_offset [6];
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_VOTE;
    in_x_coord     = '0;
    in_y_coord     = '0;
    in_pixel_value = '0;
    in_angle_index = '0;
    in_rho_index   = '0;
    cfg_valid      = 1'b0;
    cfg_rho_offset = '0;
    cur_offset     = OFFSET_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset offset. The block is still sweeping its
    // store after reset, so the first command waits on busy.
    send_vote(10'd0, 10'd0, PIXEL_ON);
    send_vote(10'd1023, 10'd1023, PIXEL_ON);
    send_vote(10'd1023, 10'd0, PIXEL_ON);
    send_vote(10'd0, 10'd1023, PIXEL_ON);
    // Pixel values other than full scale cast nothing.
    send_vote(10'd0, 10'd0, 8'd254);
    send_vote(10'd5, 10'd5, 8'd0);
    issue_command(KIND_SPARE, 10'd1023, 10'd1023, PIXEL_ON, 8'd0, 12'd1448);
    send_read(8'd0, RHO_W'(aim_rho(10'd0, 10'd0, 0)));
    send_read(8'd90, RHO_W'(aim_rho(10'd1023, 10'd0, 90)));
    send_read(8'd45, RHO_W'(aim_rho(10'd1023, 10'd1023, 45)));
    send_read(8'd179, RHO_W'(aim_rho(10'd1023, 10'd0, 179)));
    send_read(8'd179, 12'd4095);
    send_read(8'd0, 12'd0);
    // Angles past the last bin read as zero.
    send_read(8'd180, 12'd1448);
    send_read(8'd255, 12'd4095);
    // A clear is slow; the read behind it must see an empty store.
    issue_command(KIND_CLEAR, 10'd0, 10'd0, 8'd0, 8'd0, 12'd0);
    send_read(8'd0, RHO_W'(aim_rho(10'd0, 10'd0, 0)));
    wait_for_counts();

    // With an offset of one, angles whose rho goes negative cast nothing.
    write_offset(11'd1);
    send_vote(10'd1023, 10'd0, PIXEL_ON);
    send_vote(10'd1023, 10'd1023, PIXEL_ON);
    send_read(8'd0, RHO_W'(aim_rho(10'd1023, 10'd0, 0)));
    send_read(8'd179, 12'd0);
    send_read(8'd135, RHO_W'(aim_rho(10'd1023, 10'd1023, 135)));
    wait_for_counts();

    // Random phases, each at its own offset; the last runs without gaps.
    phase_offset[0] = 11'd2047;
    phase_offset[1] = 11'd0;
    phase_offset[2] = OFFSET_W'($urandom);
    phase_offset[3] = OFFSET_RESET;
    phase_offset[4] = OFFSET_W'($urandom_range(1, 1448));
    phase_offset[5] = OFFSET_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_offset(phase_offset[ph]);
      run_phase(PHASE_ITEMS, ph != 5);
    end

    // Nothing is owed any more; let the block sit idle a while before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && owed_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hlv_pkg.sv
hw/rtl/hlv_ram.sv
hw/rtl/hlv_queue.sv
hw/rtl/hlv_front.sv
hw/rtl/hlv_back.sv
hw/rtl/hough_line_vote_accumulator.sv
hw/rtl/hlv_checker.sv
dv/hlv_count_checker.sv
dv/hough_line_vote_accumulator_tb.sv
